// ----- hdl/distance_sensor_smoother_core_macros.svh -----
// Assertion macros for the distance sensor smoother core.
// Included by the modules that carry assertions; no other dependencies.
`ifndef DISTANCE_SENSOR_SMOOTHER_CORE_MACROS_SVH
`define DISTANCE_SENSOR_SMOOTHER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under a synchronous reset.
`define DSS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dss assertion failed");
// Next-cycle implication under a synchronous reset.
`define DSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dss assertion failed");
`else
`define DSS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/dss_pkg.sv -----
// Shared types and constants for the distance sensor smoother core.
// No dependencies.
package dss_pkg;

  localparam int DIST_W        = 14;
  localparam int VEL_W         = 16;
  localparam int MAG_W         = VEL_W + 1;
  localparam int LIMIT_W       = 15;
  localparam int WEIGHT_W      = 9;
  localparam int STATE_W       = 18;
  localparam int FRACTION_BITS = 4;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 16;

  // Scaled sample width and the width used for its saturation compare.
  localparam int SCALED_W = DIST_W + FRACTION_BITS;
  localparam int CMP_W    = (SCALED_W > STATE_W) ? SCALED_W : STATE_W;

  // Filter arithmetic: weight is in 1/256 units.
  localparam int ROUND_SHIFT = 8;
  localparam int PROD_W      = (WEIGHT_W + 1) + (STATE_W + 1);
  localparam int STEP_W      = PROD_W - ROUND_SHIFT;

  localparam logic [STATE_W-1:0]  STATE_MAX  = {STATE_W{1'b1}};
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(256);
  localparam logic [PROD_W-1:0]   ROUND_HALF = PROD_W'(128);

  localparam logic [DIST_W-1:0]   FLOOR_RST   = DIST_W'(50);
  localparam logic [DIST_W-1:0]   CEILING_RST = DIST_W'(2500);
  localparam logic [LIMIT_W-1:0]  MOVE_RST    = LIMIT_W'(100);
  localparam logic [LIMIT_W-1:0]  DYNAMIC_RST = LIMIT_W'(200);
  localparam logic [WEIGHT_W-1:0] STILL_RST   = WEIGHT_W'(77);
  localparam logic [WEIGHT_W-1:0] MOVING_RST  = WEIGHT_W'(128);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FLOOR         = 3'd0,
    REG_CEILING       = 3'd1,
    REG_MOVE_LIMIT    = 3'd2,
    REG_DYNAMIC_LIMIT = 3'd3,
    REG_WEIGHT_STILL  = 3'd4,
    REG_WEIGHT_MOVING = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [DIST_W-1:0]   distance_floor;
    logic [DIST_W-1:0]   distance_ceiling;
    logic [LIMIT_W-1:0]  move_limit;
    logic [LIMIT_W-1:0]  dynamic_limit;
    logic [WEIGHT_W-1:0] weight_still;
    logic [WEIGHT_W-1:0] weight_moving;
  } cfg_t;

  typedef struct packed {
    logic                moving;
    logic                dynamic;
    logic [WEIGHT_W-1:0] weight;   // saturated to WEIGHT_ONE
  } motion_t;

endpackage

// ----- hdl/dss_cfg.sv -----
// Configuration register file of the distance sensor smoother.
// Depends on dss_pkg.
module dss_cfg
  import dss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.distance_floor   <= FLOOR_RST;
      cfg.distance_ceiling <= CEILING_RST;
      cfg.move_limit       <= MOVE_RST;
      cfg.dynamic_limit    <= DYNAMIC_RST;
      cfg.weight_still     <= STILL_RST;
      cfg.weight_moving    <= MOVING_RST;
    end else if (cfg_valid) begin
      // out-of-range indexes are dropped
      unique case (reg_index_t'(cfg_index))
        REG_FLOOR:         cfg.distance_floor   <= cfg_data[DIST_W-1:0];
        REG_CEILING:       cfg.distance_ceiling <= cfg_data[DIST_W-1:0];
        REG_MOVE_LIMIT:    cfg.move_limit       <= cfg_data[LIMIT_W-1:0];
        REG_DYNAMIC_LIMIT: cfg.dynamic_limit    <= cfg_data[LIMIT_W-1:0];
        REG_WEIGHT_STILL:  cfg.weight_still     <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_MOVING: cfg.weight_moving    <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/dss_motion.sv -----
// Motion detector: velocity magnitudes, moving/dynamic flags, weight select.
// Depends on dss_pkg.
module dss_motion
  import dss_pkg::*;
(
  input  cfg_t                    cfg,
  input  logic signed [VEL_W-1:0] front_velocity,
  input  logic signed [VEL_W-1:0] back_velocity,
  input  logic signed [VEL_W-1:0] left_velocity,
  input  logic signed [VEL_W-1:0] right_velocity,
  output motion_t                 motion
);

  function automatic logic [MAG_W-1:0] mag(input logic [VEL_W-1:0] v);
    logic [MAG_W-1:0] ext;
    ext = {v[VEL_W-1], v};
    return v[VEL_W-1] ? (MAG_W'(0) - ext) : ext;
  endfunction

  logic [MAG_W-1:0]    mf, mb, ml, mr;
  logic [MAG_W-1:0]    move_lim, dyn_lim;
  logic [WEIGHT_W-1:0] w_sel;

  always_comb begin
    mf       = mag(front_velocity);
    mb       = mag(back_velocity);
    ml       = mag(left_velocity);
    mr       = mag(right_velocity);
    move_lim = MAG_W'(cfg.move_limit);
    dyn_lim  = MAG_W'(cfg.dynamic_limit);

    motion.moving  = (mf > move_lim) || (mb > move_lim);
    motion.dynamic = (mf > dyn_lim) || (mb > dyn_lim) || (ml > dyn_lim) || (mr > dyn_lim);

    w_sel = motion.moving ? cfg.weight_moving : cfg.weight_still;
    motion.weight = (w_sel > WEIGHT_ONE) ? WEIGHT_ONE : w_sel;
  end

endmodule

// ----- hdl/dss_ema_lane.sv -----
// One distance channel: clamp, scale, and exponential moving average state.
// Depends on dss_pkg.
module dss_ema_lane
  import dss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                update,
  input  logic [DIST_W-1:0]   distance_floor,
  input  logic [DIST_W-1:0]   distance_ceiling,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [DIST_W-1:0]   distance,
  output logic [STATE_W-1:0]  smoothed
);

  logic [DIST_W-1:0]        clamped;
  logic [CMP_W-1:0]         scaled;
  logic [STATE_W-1:0]       sample;
  logic signed [STATE_W:0]  diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rounded;
  logic signed [STEP_W-1:0] step;
  logic signed [STEP_W-1:0] sum;
  logic [STATE_W-1:0]       smoothed_next;

  always_comb begin
    // floor test wins when floor sits above ceiling
    priority if (distance < distance_floor) begin
      clamped = distance_floor;
    end else if (distance > distance_ceiling) begin
      clamped = distance_ceiling;
    end else begin
      clamped = distance;
    end

    scaled = CMP_W'(clamped) << FRACTION_BITS;
    sample = (scaled > CMP_W'(STATE_MAX)) ? STATE_MAX : STATE_W'(scaled);

    // s' = s + (w * (sample - s) + 128) >>> 8, same as the weighted form
    diff    = $signed({1'b0, sample}) - $signed({1'b0, smoothed});
    prod    = PROD_W'($signed({1'b0, weight}) * diff);
    rounded = prod + $signed(ROUND_HALF);
    step    = rounded[PROD_W-1:ROUND_SHIFT];
    sum     = $signed(STEP_W'(smoothed)) + step;
    smoothed_next = sum[STATE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= '0;
    end else if (update) begin
      smoothed <= smoothed_next;
    end
  end

endmodule

// ----- hdl/distance_sensor_smoother_core.sv -----
// Distance sensor smoother, top level.
// Depends on dss_pkg, dss_cfg, dss_motion, dss_ema_lane and the macros header.
//
// Usage:
//  - Input channel (in_valid/in_ready): four raw distances (mm, 14 bits) and
//    four signed velocities (mm/s, 16 bits) per item.
//  - Output channel (out_valid/out_ready): four smoothed distances in
//    1/2^FRACTION_BITS mm plus is_moving and is_dynamic flags, one per item.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//    index 0..5 = floor, ceiling, move limit, dynamic limit, still weight,
//    moving weight. Other indexes are ignored. Write only while idle.
//  - Path: the input register takes the item at the accept edge, then the
//    clamp/flag/multiply-add stage loads the results once the result stage is free.
//  - Throughput: one item per cycle while out_ready stays high, set by the
//    single multiply-add per channel closing the filter feedback combinationally.
//  - Stall: while out_ready is low the result holds and the input register
//    can still take one more item; in_ready then drops until the result moves.
//  - Reset: config registers return to their defaults, filter state clears to zero,
//    both pipeline stages empty.
`include "distance_sensor_smoother_core_macros.svh"
module distance_sensor_smoother_core
  import dss_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // config write
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // input items
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [DIST_W-1:0]       front_distance,
  input  logic [DIST_W-1:0]       back_distance,
  input  logic [DIST_W-1:0]       left_distance,
  input  logic [DIST_W-1:0]       right_distance,
  input  logic signed [VEL_W-1:0] front_velocity,
  input  logic signed [VEL_W-1:0] back_velocity,
  input  logic signed [VEL_W-1:0] left_velocity,
  input  logic signed [VEL_W-1:0] right_velocity,
  // result items
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATE_W-1:0]      front_smoothed,
  output logic [STATE_W-1:0]      back_smoothed,
  output logic [STATE_W-1:0]      left_smoothed,
  output logic [STATE_W-1:0]      right_smoothed,
  output logic                    is_moving,
  output logic                    is_dynamic
);

  cfg_t    cfg;
  motion_t motion;

  // input register stage
  logic                    s1_valid;
  logic [DIST_W-1:0]       s1_front_dist, s1_back_dist, s1_left_dist, s1_right_dist;
  logic signed [VEL_W-1:0] s1_front_vel, s1_back_vel, s1_left_vel, s1_right_vel;

  logic s1_adv;   // stage 1 item moves into the result registers
  logic in_take;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_take  = in_valid && in_ready;

  dss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_front_dist <= front_distance;
      s1_back_dist  <= back_distance;
      s1_left_dist  <= left_distance;
      s1_right_dist <= right_distance;
      s1_front_vel  <= front_velocity;
      s1_back_vel   <= back_velocity;
      s1_left_vel   <= left_velocity;
      s1_right_vel  <= right_velocity;
    end
  end

  dss_motion u_motion (
    .cfg            (cfg),
    .front_velocity (s1_front_vel),
    .back_velocity  (s1_back_vel),
    .left_velocity  (s1_left_vel),
    .right_velocity (s1_right_vel),
    .motion         (motion)
  );

  // Filter state doubles as the result register: it only changes when the
  // result stage is free, so it always matches the item being shown.
  dss_ema_lane u_lane_front (
    .clk              (clk),
    .rst              (rst),
    .update           (s1_adv),
    .distance_floor   (cfg.distance_floor),
    .distance_ceiling (cfg.distance_ceiling),
    .weight           (motion.weight),
    .distance         (s1_front_dist),
    .smoothed         (front_smoothed)
  );

  dss_ema_lane u_lane_back (
    .clk              (clk),
    .rst              (rst),
    .update           (s1_adv),
    .distance_floor   (cfg.distance_floor),
    .distance_ceiling (cfg.distance_ceiling),
    .weight           (motion.weight),
    .distance         (s1_back_dist),
    .smoothed         (back_smoothed)
  );

  dss_ema_lane u_lane_left (
    .clk              (clk),
    .rst              (rst),
    .update           (s1_adv),
    .distance_floor   (cfg.distance_floor),
    .distance_ceiling (cfg.distance_ceiling),
    .weight           (motion.weight),
    .distance         (s1_left_dist),
    .smoothed         (left_smoothed)
  );

  dss_ema_lane u_lane_right (
    .clk              (clk),
    .rst              (rst),
    .update           (s1_adv),
    .distance_floor   (cfg.distance_floor),
    .distance_ceiling (cfg.distance_ceiling),
    .weight           (motion.weight),
    .distance         (s1_right_dist),
    .smoothed         (right_smoothed)
  );

  // result valid and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      is_moving  <= motion.moving;
      is_dynamic <= motion.dynamic;
    end
  end

  // filter state must not move without an item passing through
  `DSS_ASSERT_NEXT(a_state_hold, clk, rst, !rst && !s1_adv, $stable(front_smoothed))
  // an item leaving stage 1 always lands in the result registers
  `DSS_ASSERT_NEXT(a_adv_to_out, clk, rst, s1_adv, out_valid)
  // both stages full and the receiver stalled: no more input taken
  `DSS_ASSERT_IMPLY(a_full_stall, clk, rst, s1_valid && out_valid && !out_ready, !in_ready)

endmodule

// ----- verif/smoother_checker.sv -----
// Scoreboard for distance_sensor_smoother_core: tracks register writes, predicts every
// result item from the accepted input items and compares the results field by field.
// Depends on dss_pkg.
module smoother_checker
  import dss_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [DIST_W-1:0]       front_distance,
  input  logic [DIST_W-1:0]       back_distance,
  input  logic [DIST_W-1:0]       left_distance,
  input  logic [DIST_W-1:0]       right_distance,
  input  logic signed [VEL_W-1:0] front_velocity,
  input  logic signed [VEL_W-1:0] back_velocity,
  input  logic signed [VEL_W-1:0] left_velocity,
  input  logic signed [VEL_W-1:0] right_velocity,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [STATE_W-1:0]      front_smoothed,
  input  logic [STATE_W-1:0]      back_smoothed,
  input  logic [STATE_W-1:0]      left_smoothed,
  input  logic [STATE_W-1:0]      right_smoothed,
  input  logic                    is_moving,
  input  logic                    is_dynamic,
  output int                      mismatches,
  output int                      owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRONT       = 0;
  localparam int BACK        = 1;
  localparam int LEFT        = 2;
  localparam int RIGHT       = 3;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [STATE_W-1:0] front;
    logic [STATE_W-1:0] back;
    logic [STATE_W-1:0] left;
    logic [STATE_W-1:0] right;
    logic               moving;
    logic               dynamic;
  } smoothed_t;

  cfg_t                        regs;
  logic [3:0][STATE_W-1:0]     level;
  smoothed_t                   awaited_readings [$];
  logic [3:0][DIST_W-1:0]      dist_now;
  logic [3:0][VEL_W-1:0]       vel_now;
  smoothed_t                   got;
  smoothed_t                   want;
  int                          fail_total = 0;
  int                          result_no = 0;

  // |v| of a two's complement velocity; the most negative value gives 32768.
  function automatic logic [MAG_W-1:0] speed_of(logic [VEL_W-1:0] v);
    logic [MAG_W-1:0] ext;
    ext = {v[VEL_W-1], v};
    return v[VEL_W-1] ? MAG_W'(0) - ext : ext;
  endfunction

  // Floor test first, so a floor above the ceiling still wins for low readings.
  function automatic logic [DIST_W-1:0] clamp_dist(logic [DIST_W-1:0] raw);
    if (raw < regs.distance_floor) return regs.distance_floor;
    if (raw > regs.distance_ceiling) return regs.distance_ceiling;
    return raw;
  endfunction

  function automatic logic [STATE_W-1:0] ema_next(logic [STATE_W-1:0] prev,
                                                  logic [DIST_W-1:0] raw,
                                                  logic [WEIGHT_W-1:0] w);
    logic [63:0] scaled;
    logic [63:0] acc;
    scaled = 64'(clamp_dist(raw)) << FRACTION_BITS;
    if (scaled > 64'(STATE_MAX)) scaled = 64'(STATE_MAX);
    acc = 64'(w) * scaled + (64'(WEIGHT_ONE) - 64'(w)) * 64'(prev)
        + (64'd1 << (ROUND_SHIFT - 1));
    return STATE_W'(acc >> ROUND_SHIFT);
  endfunction

  // One filter step over all four channels; updates the tracked filter state.
  function automatic smoothed_t advance_filters(logic [3:0][DIST_W-1:0] distances,
                                                logic [3:0][VEL_W-1:0] vel);
    logic [3:0][MAG_W-1:0] mag;
    logic [WEIGHT_W-1:0]   w;
    smoothed_t             r;
    for (int c = 0; c < 4; c++) mag[c] = speed_of(vel[c]);
    r.moving  = (mag[FRONT] > regs.move_limit) || (mag[BACK] > regs.move_limit);
    r.dynamic = (mag[FRONT] > regs.dynamic_limit) || (mag[BACK] > regs.dynamic_limit) ||
                (mag[LEFT] > regs.dynamic_limit) || (mag[RIGHT] > regs.dynamic_limit);
    w = r.moving ? regs.weight_moving : regs.weight_still;
    if (w > WEIGHT_ONE) w = WEIGHT_ONE;
    for (int c = 0; c < 4; c++) level[c] = ema_next(level[c], distances[c], w);
    r.front = level[FRONT];
    r.back  = level[BACK];
    r.left  = level[LEFT];
    r.right = level[RIGHT];
    return r;
  endfunction

  task automatic report(string what, logic [STATE_W-1:0] seen, logic [STATE_W-1:0] exp_val);
    // print cap keeps a badly broken run readable; every mismatch still counts
    if (fail_total < PRINT_LIMIT)
      $display("%0t ns: result %0d %s: got %0d, predicted %0d",
               $time, result_no, what, seen, exp_val);
    fail_total++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs  = '{FLOOR_RST, CEILING_RST, MOVE_RST, DYNAMIC_RST, STILL_RST, MOVING_RST};
      level = '0;
      awaited_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_FLOOR:         regs.distance_floor   = cfg_data[DIST_W-1:0];
          REG_CEILING:       regs.distance_ceiling = cfg_data[DIST_W-1:0];
          REG_MOVE_LIMIT:    regs.move_limit       = cfg_data[LIMIT_W-1:0];
          REG_DYNAMIC_LIMIT: regs.dynamic_limit    = cfg_data[LIMIT_W-1:0];
          REG_WEIGHT_STILL:  regs.weight_still     = cfg_data[WEIGHT_W-1:0];
          REG_WEIGHT_MOVING: regs.weight_moving    = cfg_data[WEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{front_smoothed, back_smoothed, left_smoothed, right_smoothed,
                is_moving, is_dynamic};
        if (awaited_readings.size() == 0) begin
          report("unexpected item, front_smoothed", got.front, '0);
        end else begin
          want = awaited_readings.pop_front();
          if (got.front !== want.front)     report("front_smoothed", got.front, want.front);
          if (got.back !== want.back)       report("back_smoothed", got.back, want.back);
          if (got.left !== want.left)       report("left_smoothed", got.left, want.left);
          if (got.right !== want.right)     report("right_smoothed", got.right, want.right);
          if (got.moving !== want.moving)   report("is_moving", got.moving, want.moving);
          if (got.dynamic !== want.dynamic) report("is_dynamic", got.dynamic, want.dynamic);
        end
        result_no++;
      end
      if (in_valid && in_ready) begin
        dist_now = {right_distance, left_distance, back_distance, front_distance};
        vel_now  = {right_velocity, left_velocity, back_velocity, front_velocity};
        awaited_readings.push_back(advance_filters(dist_now, vel_now));
      end
    end
    mismatches <= fail_total;
    owed       <= awaited_readings.size();
  end

endmodule

// ----- verif/testbench.sv -----
// Top of the distance_sensor_smoother_core testbench: clock, reset, stimulus and verdict.
// Depends on dss_pkg, the core RTL and smoother_checker.
module testbench
  import dss_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes past the last real register; writes there must be dropped.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int DRAIN_CYCLES    = 8;   // length of the quiet window after the drain

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = REG_FLOOR;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [DIST_W-1:0]       front_distance = '0;
  logic [DIST_W-1:0]       back_distance = '0;
  logic [DIST_W-1:0]       left_distance = '0;
  logic [DIST_W-1:0]       right_distance = '0;
  logic signed [VEL_W-1:0] front_velocity = '0;
  logic signed [VEL_W-1:0] back_velocity = '0;
  logic signed [VEL_W-1:0] left_velocity = '0;
  logic signed [VEL_W-1:0] right_velocity = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STATE_W-1:0]      front_smoothed;
  logic [STATE_W-1:0]      back_smoothed;
  logic [STATE_W-1:0]      left_smoothed;
  logic [STATE_W-1:0]      right_smoothed;
  logic                    is_moving;
  logic                    is_dynamic;
  int                      mismatches;
  int                      owed;

  // Stimulus shaping only: what was last programmed, and a slowly wandering
  // "true" distance per channel so the filters settle and track.
  cfg_t                    shadow = '{FLOOR_RST, CEILING_RST, MOVE_RST, DYNAMIC_RST,
                                      STILL_RST, MOVING_RST};
  logic [3:0][DIST_W-1:0]  scene = '0;
  logic                    steady = 1'b0;   // phase with no idling on either side
  int unsigned             stall_left = 0;

  distance_sensor_smoother_core DUT (.*);

  smoother_checker checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver backpressure. A stall starts on a quarter of the cycles outside
  // steady phases; length drawn like the sender's gaps but never zero.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      stall_left <= idle_length();
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Drop valid, then wait until every predicted item has come out. The
  // first edge lets the checker see an item accepted in this very step.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
  endtask

  // Leaves cfg_valid high so back-to-back writes follow without a gap.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Full register set plus one write to an unused index, only while idle.
  task automatic program_regs(logic [CFG_DATA_W-1:0] fl, logic [CFG_DATA_W-1:0] ce,
                              logic [CFG_DATA_W-1:0] mv, logic [CFG_DATA_W-1:0] dy,
                              logic [CFG_DATA_W-1:0] ws, logic [CFG_DATA_W-1:0] wm);
    wait_idle();
    write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(REG_FLOOR, fl);
    write_reg(REG_CEILING, ce);
    write_reg(REG_MOVE_LIMIT, mv);
    write_reg(REG_DYNAMIC_LIMIT, dy);
    write_reg(REG_WEIGHT_STILL, ws);
    write_reg(REG_WEIGHT_MOVING, wm);
    cfg_valid <= 1'b0;
    shadow = '{fl[DIST_W-1:0], ce[DIST_W-1:0], mv[LIMIT_W-1:0], dy[LIMIT_W-1:0],
               ws[WEIGHT_W-1:0], wm[WEIGHT_W-1:0]};
  endtask

  // One item; valid stays up across back-to-back items and only drops for a gap.
  task automatic send(logic [DIST_W-1:0] fd, logic [DIST_W-1:0] bd,
                      logic [DIST_W-1:0] ld, logic [DIST_W-1:0] rd,
                      logic [VEL_W-1:0] fv, logic [VEL_W-1:0] bv,
                      logic [VEL_W-1:0] lv, logic [VEL_W-1:0] rv);
    int unsigned gap;
    in_valid       <= 1'b1;
    front_distance <= fd;
    back_distance  <= bd;
    left_distance  <= ld;
    right_distance <= rd;
    front_velocity <= fv;
    back_velocity  <= bv;
    left_velocity  <= lv;
    right_velocity <= rv;
    do @(posedge clk); while (!in_ready);
    gap = steady ? 0 : idle_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Velocities cluster around the given threshold so both sides of the
  // strict compare show up; a quarter are anything in the 16-bit range.
  function automatic logic [VEL_W-1:0] rand_velocity(logic [LIMIT_W-1:0] limit);
    int unsigned m;
    m = $urandom_range(0, 2 * int'(limit) + 2);
    case ($urandom_range(0, 7))
      0, 1: m = $urandom;
      2:    m = 32'(limit);
      3:    m = 32'(limit) + 32'd1;
      default: ;
    endcase
    return $urandom_range(0, 1) ? VEL_W'(-m) : VEL_W'(m);
  endfunction

  // Mostly values in range; a quarter raw 16-bit data to hit the upper bits.
  function automatic logic [CFG_DATA_W-1:0] rand_setting(int unsigned hi);
    if ($urandom_range(0, 3) == 0) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(0, hi));
  endfunction

  task automatic send_random();
    logic [3:0][DIST_W-1:0] d;
    logic [3:0][VEL_W-1:0]  v;
    for (int c = 0; c < 4; c++) begin
      scene[c] = scene[c] + DIST_W'($urandom_range(0, 32)) - DIST_W'(16);
      case ($urandom_range(0, 9))
        0, 1: d[c] = DIST_W'($urandom);
        2:    d[c] = shadow.distance_floor + DIST_W'($urandom_range(0, 2)) - DIST_W'(1);
        3:    d[c] = shadow.distance_ceiling + DIST_W'($urandom_range(0, 2)) - DIST_W'(1);
        default: d[c] = scene[c] + DIST_W'($urandom_range(0, 64)) - DIST_W'(32);
      endcase
      // front and back sometimes probe the move threshold, else the dynamic one
      v[c] = rand_velocity((c < 2 && $urandom_range(0, 1)) ? shadow.move_limit
                                                           : shadow.dynamic_limit);
    end
    send(d[0], d[1], d[2], d[3], v[0], v[1], v[2], v[3]);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset settings: clamp edges, strict thresholds, |min velocity|.
    send(14'd0, 14'd0, 14'd0, 14'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF,
         16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send(14'd49, 14'd50, 14'd51, 14'd2500, 16'h8000, 16'd0, 16'd0, 16'd0);
    send(14'd2499, 14'd2501, 14'h3FFF, 14'd0, 16'd100, -16'sd100, 16'd200, -16'sd200);
    send(14'd1000, 14'd1000, 14'd1000, 14'd1000, 16'd101, 16'd0, 16'd0, 16'd0);
    send(14'd1000, 14'd1000, 14'd1000, 14'd1000, 16'd0, -16'sd101, 16'd0, 16'd0);
    send(14'd2000, 14'd300, 14'd60, 14'd2400, 16'd0, 16'd0, 16'd201, 16'd0);
    send(14'd2000, 14'd300, 14'd60, 14'd2400, 16'd0, 16'd0, 16'd0, -16'sd201);
    send(14'd1, 14'd2, 14'd3, 14'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(14'h2AAA, 14'h1555, 14'd777, 14'd1234, 16'd0, 16'h8000, 16'd0, 16'h7FFF);

    // Directed, floor above ceiling, weights past 256, thresholds at both ends.
    program_regs(16'd3000, 16'd1000, 16'd0, 16'd32767, 16'd511, 16'd300);
    send(14'd2999, 14'd3000, 14'd3001, 14'd500, 16'd0, 16'd0, 16'd0, 16'd0);
    send(14'h3FFF, 14'd0, 14'd1000, 14'd999, 16'd1, 16'd0, 16'd0, 16'd0);
    send(14'd3001, 14'd2999, 14'd0, 14'h3FFF, 16'd0, 16'hFFFF, 16'h8000, 16'h7FFF);
    send(14'd1001, 14'd1001, 14'd1001, 14'd1001, 16'h8000, 16'h8000, 16'h8000, 16'h8000);

    // Random phases: extremes first, then the reset values, one more extreme set, then random sets.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_regs(16'd0, 16'd16383, 16'd0, 16'd0, 16'd0, 16'd256);
        1: program_regs(16'd16383, 16'd16383, 16'd32767, 16'd32767, 16'd256, 16'd0);
        2: program_regs(CFG_DATA_W'(FLOOR_RST), CFG_DATA_W'(CEILING_RST),
                        CFG_DATA_W'(MOVE_RST), CFG_DATA_W'(DYNAMIC_RST),
                        CFG_DATA_W'(STILL_RST), CFG_DATA_W'(MOVING_RST));
        3: program_regs(16'd16383, 16'd0, 16'd100, 16'd200, 16'hFFFF, 16'd257);
        default: program_regs(rand_setting(3000), rand_setting(16383), rand_setting(1000),
                              rand_setting(2000), rand_setting(256), rand_setting(256));
      endcase
      steady <= (p % 3 == 2);
      for (int c = 0; c < 4; c++)
        scene[c] = DIST_W'($urandom_range(shadow.distance_floor, shadow.distance_ceiling));
      repeat (ITEMS_PER_PHASE) send_random();
    end

    // Drain, then a short quiet window to catch stray results.
    wait_idle();
    steady <= 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/dss_pkg.sv
hdl/dss_cfg.sv
hdl/dss_motion.sv
hdl/dss_ema_lane.sv
hdl/distance_sensor_smoother_core.sv
verif/smoother_checker.sv
verif/testbench.sv
